/* src/brcm_pkg.sv */
// Package for the byte ring chunk manager: transaction structs,
// operation and status codes. No dependencies.
`default_nettype none
package brcm_pkg;
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_FREE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_NOTHING  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [12:0] send_length;
    logic [11:0] chunk_offset;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] offset;
    logic [12:0] size;
    logic        space_released;
    logic [12:0] used_count;
    logic [12:0] unread_count;
  } out_t;
endpackage
`default_nettype wire

/* src/byte_ring_chunk_manager.sv */
// Byte ring space manager with a chunk table held in a synchronous memory.
// Send and receive: result registered and shown in the cycle after start, next start accepted at once.
// Free: busy while it walks the chunk table memory (one read per step): a search
//   (read, check per entry), then retirement of released chunks from the head;
//   the result shows in the first cycle with busy low.
// Reset (rst_n low, synchronous) and any cfg write empty the ring and table.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
// Depends on brcm_pkg.
`default_nettype none
module byte_ring_chunk_manager #(
  parameter int BUF_BYTES  = 4096,
  parameter int MAX_CHUNKS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  brcm_pkg::in_t       in_data,
  output logic                out_valid,
  output brcm_pkg::out_t      out_data,
  input  wire                 cfg_we,
  input  wire  [12:0]         cfg_wdata
);
  import brcm_pkg::*;

  localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [12:0] RS_MAX = 13'((BUF_BYTES > 4096) ? 4096 : BUF_BYTES);
  localparam logic [CW:0] MAXC = (CW + 1)'(MAX_CHUNKS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FIND_RD  = 3'd1;
  localparam logic [2:0] S_FIND_CHK = 3'd2;
  localparam logic [2:0] S_RET      = 3'd3;
  localparam logic [2:0] S_RET_CHK  = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [12:0]  ring_r, ring_nxt;
  logic [11:0]  wo_r, wo_nxt, ro_r, ro_nxt, tail_r, tail_nxt;
  logic [12:0]  used_r, used_nxt, unread_r, unread_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [MAX_CHUNKS-1:0] rel_r, rel_nxt;
  logic [11:0]  at_r, at_nxt;
  logic         found_r, found_nxt, freed_r, freed_nxt;
  logic         ov_r, ov_nxt;
  out_t         out_r, out_nxt;

  // chunk table: {start, length}
  logic [24:0]  mem [MAX_CHUNKS];
  logic [24:0]  rd_q;
  logic [IW-1:0] rd_addr, wr_addr;
  logic         wr_en;
  logic [24:0]  wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW + 1)'(a) + (CW + 1)'(b);
    if (s >= MAXC) s = s - MAXC;
    return s[IW-1:0];
  endfunction

  logic [12:0] free_sp, room, rsize, n_ret;
  logic [13:0] wsum, rsum, tsum;

  always_comb begin
    state_nxt = state_r; ring_nxt = ring_r; wo_nxt = wo_r; ro_nxt = ro_r;
    tail_nxt = tail_r; used_nxt = used_r; unread_nxt = unread_r;
    head_nxt = head_r; cnt_nxt = cnt_r; idx_nxt = idx_r; rel_nxt = rel_r;
    at_nxt = at_r; found_nxt = found_r; freed_nxt = freed_r;
    ov_nxt = 1'b0; out_nxt = out_r;
    wr_en = 1'b0; wr_addr = wrap_add(head_r, cnt_r);
    wr_data = {ro_r, 13'd0};
    rd_addr = head_r;
    free_sp = ring_r - used_r;
    wsum = {2'b0, wo_r} + {1'b0, in_data.send_length};
    room = ring_r - {1'b0, ro_r};
    rsize = (unread_r < room) ? unread_r : room;
    rsum = {2'b0, ro_r} + {1'b0, rsize};
    n_ret = (rd_q[12:0] > used_r) ? used_r : rd_q[12:0];
    tsum = {2'b0, tail_r} + {1'b0, n_ret};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_nxt = '0;
          case (in_data.operation)
            OP_SEND: begin
              ov_nxt = 1'b1;
              if (free_sp < in_data.send_length) begin
                out_nxt.status = ST_NO_SPACE;
              end else begin
                out_nxt.offset = wo_r;
                if (wsum >= {1'b0, ring_r}) wsum = wsum - {1'b0, ring_r};
                wo_nxt = wsum[11:0];
                used_nxt = used_r + in_data.send_length;
                unread_nxt = unread_r + in_data.send_length;
              end
            end
            OP_RECV: begin
              ov_nxt = 1'b1;
              if (unread_r == 13'd0) begin
                out_nxt.status = ST_NOTHING;
              end else if ((CW + 1)'(cnt_r) >= MAXC) begin
                out_nxt.status = ST_FULL;
              end else begin
                out_nxt.offset = ro_r;
                out_nxt.size = rsize;
                wr_en = 1'b1;
                wr_data = {ro_r, rsize};
                rel_nxt[wr_addr] = 1'b0;
                cnt_nxt = cnt_r + 1'b1;
                if (rsum >= {1'b0, ring_r}) rsum = rsum - {1'b0, ring_r};
                ro_nxt = rsum[11:0];
                unread_nxt = unread_r - rsize;
              end
            end
            OP_FREE: begin
              at_nxt = in_data.chunk_offset;
              idx_nxt = '0;
              found_nxt = 1'b0;
              freed_nxt = 1'b0;
              state_nxt = (cnt_r == '0) ? S_RET : S_FIND_RD;
            end
            default: begin
              ov_nxt = 1'b1;
              out_nxt.used_count = used_r;
              out_nxt.unread_count = unread_r;
            end
          endcase
          if (in_data.operation != OP_FREE) begin
            out_nxt.used_count = used_nxt;
            out_nxt.unread_count = unread_nxt;
          end
        end
      end
      S_FIND_RD: begin
        rd_addr = wrap_add(head_r, idx_r);
        state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (rd_q[24:13] == at_r) begin
          rel_nxt[wrap_add(head_r, idx_r)] = 1'b1;
          found_nxt = 1'b1;
          state_nxt = S_RET;
        end else if (idx_r + 1'b1 == cnt_r) begin
          state_nxt = S_RET;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_FIND_RD;
        end
      end
      S_RET: begin
        rd_addr = head_r;
        if (cnt_r != '0 && rel_r[head_r]) begin
          state_nxt = S_RET_CHK;
        end else begin
          ov_nxt = 1'b1;
          out_nxt = '0;
          out_nxt.status = found_r ? ST_OK : ST_UNKNOWN;
          out_nxt.space_released = freed_r;
          out_nxt.used_count = used_r;
          out_nxt.unread_count = unread_r;
          state_nxt = S_IDLE;
        end
      end
      S_RET_CHK: begin
        if (tsum >= {1'b0, ring_r}) tsum = tsum - {1'b0, ring_r};
        tail_nxt = tsum[11:0];
        used_nxt = used_r - n_ret;
        head_nxt = wrap_add(head_r, CW'(1));
        cnt_nxt = cnt_r - 1'b1;
        freed_nxt = 1'b1;
        state_nxt = S_RET;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      if (cfg_wdata == 13'd0) ring_nxt = 13'd1;
      else if (cfg_wdata > RS_MAX) ring_nxt = RS_MAX;
      else ring_nxt = cfg_wdata;
      wo_nxt = '0; ro_nxt = '0; tail_nxt = '0; used_nxt = '0; unread_nxt = '0;
      head_nxt = '0; cnt_nxt = '0; state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ring_r <= RS_MAX; wo_r <= '0; ro_r <= '0;
      tail_r <= '0; used_r <= '0; unread_r <= '0; head_r <= '0; cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ring_r <= ring_nxt; wo_r <= wo_nxt; ro_r <= ro_nxt;
      tail_r <= tail_nxt; used_r <= used_nxt; unread_r <= unread_nxt;
      head_r <= head_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; rel_r <= rel_nxt; at_r <= at_nxt;
    found_r <= found_nxt; freed_r <= freed_nxt; out_r <= out_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data = out_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(cnt_r) <= MAXC) else $error("chunk count overflow");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= ring_r) else $error("used exceeds ring size");
  a_unread: assert property (@(posedge clk) disable iff (!rst_n)
    unread_r <= used_r) else $error("unread exceeds used");
  a_quick: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_we && in_data.operation != OP_FREE |=> out_valid)
    else $error("send/receive result missing");
endmodule
`default_nettype wire
